// File: src/packed_datetime_comparator_macros.svh
// ---------------------------------------------------------------------------
// Packed date/time comparator assertion macros
// Shorthand for the clocked, reset-qualified assertions of the checker.
// ---------------------------------------------------------------------------
`ifndef PACKED_DATETIME_COMPARATOR_MACROS_SVH
`define PACKED_DATETIME_COMPARATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define PDTC_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define PDTC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/pdtc_pkg.sv
// ---------------------------------------------------------------------------
// Packed date/time comparator package
// Field layout, arithmetic widths, codes and tables shared by the block.
// ---------------------------------------------------------------------------
package pdtc_pkg;

	// Packed field word layout
	localparam int BITS_W      = 54;
	localparam int YEAR_LSB    = 40;
	localparam int YEAR_W      = 14;
	localparam int MONTH_LSB   = 36;
	localparam int MONTH_W     = 4;
	localparam int DAY_LSB     = 31;
	localparam int DAY_W       = 5;
	localparam int HOUR_LSB    = 26;
	localparam int HOUR_W      = 5;
	localparam int MINUTE_LSB  = 20;
	localparam int MINUTE_W    = 6;
	localparam int SECOND_LSB  = 14;
	localparam int SECOND_W    = 6;
	localparam int HAS_TZ_BIT  = 13;
	localparam int TZ_SIGN_BIT = 12;
	localparam int TZ_HOUR_LSB = 7;
	localparam int TZ_HOUR_W   = 5;
	localparam int TZ_MIN_LSB  = 1;
	localparam int TZ_MIN_W    = 6;

	// Low-precision operands keep their year in the low bits of the word
	localparam int LOW_YEAR_BITS = 40;

	// Result and wide year arithmetic
	localparam int DIFF_W = 43;
	localparam int WIDE_W = BITS_W + 3;

	// Timeline arithmetic widths
	localparam int PREV_W      = YEAR_W + 1;
	localparam int RECIP_W     = 13;
	localparam int RECIP_SHIFT = 19;
	localparam int PROD_W      = PREV_W + RECIP_W;
	localparam int Q100_W      = 8;
	localparam int TZ_W        = 11;
	localparam int TZO_W       = 12;
	localparam int SOD_W       = 19;
	localparam int LEAP_W      = 13;
	localparam int MDAY_W      = 9;
	localparam int DAYS_W      = 24;
	localparam int SECS_W      = 42;

	// x / 100 == (x * RECIP_100) >> RECIP_SHIFT for every x below 43690
	localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;
	localparam logic [YEAR_W-1:0]  CENTURY   = 14'd100;

	localparam logic [MONTH_W-1:0] MONTH_MARCH = 4'd3;
	localparam logic [TZ_W-1:0]    TZ_MIN_PER_HOUR = 11'd60;

	localparam logic signed [DAYS_W-1:0] DAYS_YEAR  = 24'sd365;
	localparam logic signed [SECS_W-1:0] SEC_DAY_C  = 42'sd86400;
	localparam logic signed [SOD_W-1:0]  SEC_HOUR_C = 19'sd3600;
	localparam logic signed [SOD_W-1:0]  SEC_MIN_C  = 19'sd60;

	// Fourteen hours either side of zero
	localparam logic signed [DIFF_W-1:0] TZ_WINDOW = 43'sd50400;

	// Saturation bounds of the result, held at the wide year width
	localparam logic signed [WIDE_W-1:0] YDIFF_MAX =
		{{(WIDE_W-DIFF_W+1){1'b0}}, {(DIFF_W-1){1'b1}}};
	localparam logic signed [WIDE_W-1:0] YDIFF_MIN =
		{{(WIDE_W-DIFF_W+1){1'b1}}, {(DIFF_W-1){1'b0}}};

	typedef enum logic [1:0] {
		MODE_NORMAL,
		MODE_STRICT,
		MODE_STRICT_EQ,
		MODE_ALT
	} mode_t;

	typedef enum logic [1:0] {
		SUB_DATE,
		SUB_DATETIME,
		SUB_TIME,
		SUB_STAMP
	} subtype_t;

	// Load enables of the timeline stages
	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
	} stage_en_t;

	// Days in the year before the first of a month; 13 to 15 count a full year
	function automatic logic [MDAY_W-1:0] days_before_month(input logic [MONTH_W-1:0] m);
		logic [MDAY_W-1:0] d;
		case (m)
			4'd0:    d = 9'd0;
			4'd1:    d = 9'd0;
			4'd2:    d = 9'd31;
			4'd3:    d = 9'd59;
			4'd4:    d = 9'd90;
			4'd5:    d = 9'd120;
			4'd6:    d = 9'd151;
			4'd7:    d = 9'd181;
			4'd8:    d = 9'd212;
			4'd9:    d = 9'd243;
			4'd10:   d = 9'd273;
			4'd11:   d = 9'd304;
			4'd12:   d = 9'd334;
			default: d = 9'd365;
		endcase
		return d;
	endfunction

endpackage

// File: src/pdtc_timeline.sv
// ---------------------------------------------------------------------------
// Packed date/time to UTC seconds
// Three-stage conversion of one operand to seconds on a proleptic Gregorian
// timeline: leap-day quotients, day count, then scaling to seconds.
// ---------------------------------------------------------------------------
module pdtc_timeline (
	input  logic                                 clk,
	input  pdtc_pkg::stage_en_t                  en,
	input  logic [1:0]                           subtype,
	input  logic                                 negative,
	input  logic [pdtc_pkg::BITS_W-1:0]          bits,
	output logic signed [pdtc_pkg::SECS_W-1:0]   secs
);

	// Stage 2 inputs
	logic                                   is_time;
	logic                                   is_date;
	logic [pdtc_pkg::YEAR_W-1:0]            mag;
	logic [pdtc_pkg::YEAR_W-1:0]            abs_y_c;
	logic signed [pdtc_pkg::PREV_W-1:0]     year_c;
	logic signed [pdtc_pkg::PREV_W-1:0]     prev_c;
	logic [pdtc_pkg::PREV_W-1:0]            abs_p_c;
	logic [pdtc_pkg::PROD_W-1:0]            prod_y;
	logic [pdtc_pkg::PROD_W-1:0]            prod_p;
	logic [pdtc_pkg::HOUR_W-1:0]            hour_c;
	logic [pdtc_pkg::MINUTE_W-1:0]          minute_c;
	logic [pdtc_pkg::SECOND_W-1:0]          second_c;
	logic [pdtc_pkg::TZ_W-1:0]              tz_mag;
	logic signed [pdtc_pkg::TZO_W-1:0]      tz_off;
	logic signed [pdtc_pkg::TZO_W-1:0]      min_rel;
	logic signed [pdtc_pkg::SOD_W-1:0]      sod_c;

	// Stage 2 registers
	logic signed [pdtc_pkg::PREV_W-1:0]     prev_s2;
	logic [pdtc_pkg::PREV_W-1:0]            abs_p_s2;
	logic [pdtc_pkg::Q100_W-1:0]            q100p_s2;
	logic [pdtc_pkg::YEAR_W-1:0]            abs_y_s2;
	logic [pdtc_pkg::Q100_W-1:0]            q100y_s2;
	logic [pdtc_pkg::MONTH_W-1:0]           month_s2;
	logic [pdtc_pkg::DAY_W-1:0]             day_s2;
	logic signed [pdtc_pkg::SOD_W-1:0]      sod_s2;

	// Stage 3 logic and registers
	logic [pdtc_pkg::LEAP_W-1:0]            leap_mag;
	logic signed [pdtc_pkg::DAYS_W-1:0]     leap_days;
	logic                                   div100;
	logic                                   leap_year;
	logic [pdtc_pkg::MDAY_W-1:0]            mdays;
	logic signed [pdtc_pkg::DAYS_W-1:0]     days_c;
	logic signed [pdtc_pkg::DAYS_W-1:0]     days_s3;
	logic signed [pdtc_pkg::SOD_W-1:0]      sod_s3;

	logic signed [pdtc_pkg::SECS_W-1:0]     secs_s4;

	// Year, previous year and their hundreds by reciprocal multiplication
	always_comb begin
		is_time = (subtype == pdtc_pkg::SUB_TIME);
		is_date = (subtype == pdtc_pkg::SUB_DATE);
		mag     = bits[pdtc_pkg::YEAR_LSB +: pdtc_pkg::YEAR_W];
		abs_y_c = is_time ? pdtc_pkg::YEAR_W'(1) : mag;
		if (is_time) begin
			year_c = pdtc_pkg::PREV_W'(1);
		end else if (negative) begin
			year_c = -$signed({1'b0, mag});
		end else begin
			year_c = $signed({1'b0, mag});
		end
		prev_c  = year_c - pdtc_pkg::PREV_W'(1);
		abs_p_c = prev_c[pdtc_pkg::PREV_W-1] ? pdtc_pkg::PREV_W'(-prev_c)
		                                     : pdtc_pkg::PREV_W'(prev_c);
		prod_y  = pdtc_pkg::PROD_W'(abs_y_c) * pdtc_pkg::PROD_W'(pdtc_pkg::RECIP_100);
		prod_p  = pdtc_pkg::PROD_W'(abs_p_c) * pdtc_pkg::PROD_W'(pdtc_pkg::RECIP_100);
	end

	// Seconds within the day, timezone offset taken off the minutes
	always_comb begin
		hour_c   = is_date ? '0 : bits[pdtc_pkg::HOUR_LSB +: pdtc_pkg::HOUR_W];
		minute_c = is_date ? '0 : bits[pdtc_pkg::MINUTE_LSB +: pdtc_pkg::MINUTE_W];
		second_c = is_date ? '0 : bits[pdtc_pkg::SECOND_LSB +: pdtc_pkg::SECOND_W];
		tz_mag   = pdtc_pkg::TZ_W'(bits[pdtc_pkg::TZ_HOUR_LSB +: pdtc_pkg::TZ_HOUR_W])
		         * pdtc_pkg::TZ_MIN_PER_HOUR
		         + pdtc_pkg::TZ_W'(bits[pdtc_pkg::TZ_MIN_LSB +: pdtc_pkg::TZ_MIN_W]);
		if (!bits[pdtc_pkg::HAS_TZ_BIT]) begin
			tz_off = '0;
		end else if (bits[pdtc_pkg::TZ_SIGN_BIT]) begin
			tz_off = -$signed({1'b0, tz_mag});
		end else begin
			tz_off = $signed({1'b0, tz_mag});
		end
		min_rel = $signed(pdtc_pkg::TZO_W'(minute_c)) - tz_off;
		sod_c   = $signed(pdtc_pkg::SOD_W'(hour_c)) * pdtc_pkg::SEC_HOUR_C
		        + pdtc_pkg::SOD_W'(min_rel) * pdtc_pkg::SEC_MIN_C
		        + $signed(pdtc_pkg::SOD_W'(second_c));
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			prev_s2  <= prev_c;
			abs_p_s2 <= abs_p_c;
			q100p_s2 <= prod_p[pdtc_pkg::RECIP_SHIFT +: pdtc_pkg::Q100_W];
			abs_y_s2 <= abs_y_c;
			q100y_s2 <= prod_y[pdtc_pkg::RECIP_SHIFT +: pdtc_pkg::Q100_W];
			month_s2 <= is_time ? pdtc_pkg::MONTH_W'(1)
			                    : bits[pdtc_pkg::MONTH_LSB +: pdtc_pkg::MONTH_W];
			day_s2   <= is_time ? pdtc_pkg::DAY_W'(1)
			                    : bits[pdtc_pkg::DAY_LSB +: pdtc_pkg::DAY_W];
			sod_s2   <= sod_c;
		end
	end

	// Day count: whole years, truncated leap days, month start and day
	always_comb begin
		// prev/4 - prev/100 + prev/400 on the magnitude, sign restored after
		leap_mag  = pdtc_pkg::LEAP_W'(abs_p_s2 >> 2)
		          + pdtc_pkg::LEAP_W'(q100p_s2 >> 2)
		          - pdtc_pkg::LEAP_W'(q100p_s2);
		leap_days = prev_s2[pdtc_pkg::PREV_W-1] ? -$signed(pdtc_pkg::DAYS_W'(leap_mag))
		                                        : $signed(pdtc_pkg::DAYS_W'(leap_mag));
		div100    = (abs_y_s2 == pdtc_pkg::YEAR_W'(q100y_s2) * pdtc_pkg::CENTURY);
		leap_year = (abs_y_s2[1:0] == 2'b00) && (!div100 || (q100y_s2[1:0] == 2'b00));
		mdays     = pdtc_pkg::days_before_month(month_s2)
		          + pdtc_pkg::MDAY_W'(leap_year && (month_s2 >= pdtc_pkg::MONTH_MARCH));
		days_c    = pdtc_pkg::DAYS_W'(prev_s2) * pdtc_pkg::DAYS_YEAR
		          + leap_days
		          + $signed(pdtc_pkg::DAYS_W'(mdays))
		          + $signed(pdtc_pkg::DAYS_W'(day_s2))
		          - pdtc_pkg::DAYS_W'(1);
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			days_s3 <= days_c;
			sod_s3  <= sod_s2;
		end
	end

	// Scale days to seconds
	always_ff @(posedge clk) begin
		if (en.s4) begin
			secs_s4 <= pdtc_pkg::SECS_W'(days_s3) * pdtc_pkg::SEC_DAY_C
			         + pdtc_pkg::SECS_W'(sod_s3);
		end
	end

	assign secs = secs_s4;

endmodule

// File: src/packed_datetime_comparator.sv
// ---------------------------------------------------------------------------
// Packed date/time comparator
// Compares two packed date/time values and returns left minus right.
// ---------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid/req_ready) carries the mode and both operands;
//   result channel (res_valid/res_ready) returns the signed difference, in
//   seconds or, when either side is low precision, in years, plus the
//   indeterminate flag of the strict modes.
//   Pipeline: a transaction accepted on the request port passes, when
//   nothing stalls, to the result port through five register stages:
//   input, leap quotients, day count, seconds, result.
//   Throughput: one transaction per cycle when not stalled; each stage has
//   its own valid bit, so requests keep coming in until every stage is full.
//   The reciprocal divisions, the day count and the days-to-seconds product
//   each take a stage and set the depth.
//   Stall: while res_ready is low the result holds; request acceptance stops
//   only once all stages behind the result register hold a transaction.
//   Reset: arst_n clears every valid bit; no result is presented after
//   reset until a request has passed through.
// ---------------------------------------------------------------------------
module packed_datetime_comparator (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_ready,
	input  logic [1:0]                          req_type,
	input  logic [1:0]                          lhs_kind,
	input  logic                                lhs_negative,
	input  logic                                lhs_low_precision,
	input  logic [pdtc_pkg::BITS_W-1:0]         lhs_bits,
	input  logic [1:0]                          rhs_kind,
	input  logic                                rhs_negative,
	input  logic                                rhs_low_precision,
	input  logic [pdtc_pkg::BITS_W-1:0]         rhs_bits,
	output logic                                res_valid,
	input  logic                                res_ready,
	output logic signed [pdtc_pkg::DIFF_W-1:0]  difference,
	output logic                                indeterminate
);

	// Result decided without the timeline, or how to finish it
	typedef struct packed {
		logic                               fixed;
		logic                               check_tz;
		logic                               indet;
		logic signed [pdtc_pkg::DIFF_W-1:0] diff;
	} ctl_t;

	// Valid bits and stage readiness
	logic v_s1, v_s2, v_s3, v_s4, res_valid_q;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;
	pdtc_pkg::stage_en_t en;

	// Input register
	logic [1:0]                  req_type_s1;
	logic [1:0]                  lhs_kind_s1, rhs_kind_s1;
	logic                        lhs_negative_s1, rhs_negative_s1;
	logic                        lhs_low_precision_s1, rhs_low_precision_s1;
	logic [pdtc_pkg::BITS_W-1:0] lhs_bits_s1, rhs_bits_s1;

	// Decision logic
	logic                               identical;
	logic                               compat;
	logic                               lhs_dt, rhs_dt;
	logic [pdtc_pkg::WIDE_W-1:0]        lhs_mag, rhs_mag;
	logic signed [pdtc_pkg::WIDE_W-1:0] lhs_year, rhs_year, ydiff;
	logic signed [pdtc_pkg::DIFF_W-1:0] ysat;
	ctl_t                               ctl_c, ctl_s2, ctl_s3, ctl_s4;

	logic signed [pdtc_pkg::SECS_W-1:0] lhs_secs, rhs_secs;
	logic signed [pdtc_pkg::DIFF_W-1:0] tdiff;
	logic                               in_window;

	logic signed [pdtc_pkg::DIFF_W-1:0] difference_q;
	logic                               indeterminate_q;

	// Each stage loads when empty or when the next one moves on
	always_comb begin
		rdy5 = !res_valid_q || res_ready;
		rdy4 = !v_s4 || rdy5;
		rdy3 = !v_s3 || rdy4;
		rdy2 = !v_s2 || rdy3;
		rdy1 = !v_s1 || rdy2;
		en.s2 = rdy2;
		en.s3 = rdy3;
		en.s4 = rdy4;
	end

	assign req_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= req_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) res_valid_q <= v_s4;
		end
	end

	// Input register
	always_ff @(posedge clk) begin
		if (rdy1) begin
			req_type_s1          <= req_type;
			lhs_kind_s1          <= lhs_kind;
			lhs_negative_s1      <= lhs_negative;
			lhs_low_precision_s1 <= lhs_low_precision;
			lhs_bits_s1          <= lhs_bits;
			rhs_kind_s1          <= rhs_kind;
			rhs_negative_s1      <= rhs_negative;
			rhs_low_precision_s1 <= rhs_low_precision;
			rhs_bits_s1          <= rhs_bits;
		end
	end

	// Identity, subtype compatibility and the signed-year difference
	always_comb begin
		identical = (lhs_kind_s1 == rhs_kind_s1)
		         && (lhs_negative_s1 == rhs_negative_s1)
		         && (lhs_low_precision_s1 == rhs_low_precision_s1)
		         && (lhs_bits_s1 == rhs_bits_s1);
		lhs_dt = (lhs_kind_s1 == pdtc_pkg::SUB_DATETIME)
		      || (lhs_kind_s1 == pdtc_pkg::SUB_STAMP);
		rhs_dt = (rhs_kind_s1 == pdtc_pkg::SUB_DATETIME)
		      || (rhs_kind_s1 == pdtc_pkg::SUB_STAMP);
		if (req_type_s1 == pdtc_pkg::MODE_ALT) begin
			compat = (lhs_kind_s1 == rhs_kind_s1)
			      || ((lhs_kind_s1 != pdtc_pkg::SUB_TIME)
			       && (rhs_kind_s1 != pdtc_pkg::SUB_TIME));
		end else begin
			compat = (lhs_kind_s1 == rhs_kind_s1) || (lhs_dt && rhs_dt);
		end

		lhs_mag = lhs_low_precision_s1
		        ? pdtc_pkg::WIDE_W'(lhs_bits_s1[pdtc_pkg::LOW_YEAR_BITS-1:0])
		        : pdtc_pkg::WIDE_W'(lhs_bits_s1[pdtc_pkg::YEAR_LSB +: pdtc_pkg::YEAR_W]);
		rhs_mag = rhs_low_precision_s1
		        ? pdtc_pkg::WIDE_W'(rhs_bits_s1[pdtc_pkg::LOW_YEAR_BITS-1:0])
		        : pdtc_pkg::WIDE_W'(rhs_bits_s1[pdtc_pkg::YEAR_LSB +: pdtc_pkg::YEAR_W]);
		lhs_year = lhs_negative_s1 ? -$signed(lhs_mag) : $signed(lhs_mag);
		rhs_year = rhs_negative_s1 ? -$signed(rhs_mag) : $signed(rhs_mag);
		ydiff    = lhs_year - rhs_year;
		if (ydiff > pdtc_pkg::YDIFF_MAX) begin
			ysat = pdtc_pkg::DIFF_W'(pdtc_pkg::YDIFF_MAX);
		end else if (ydiff < pdtc_pkg::YDIFF_MIN) begin
			ysat = pdtc_pkg::DIFF_W'(pdtc_pkg::YDIFF_MIN);
		end else begin
			ysat = pdtc_pkg::DIFF_W'(ydiff);
		end
	end

	// Settle the result here unless it needs the timeline
	always_comb begin
		ctl_c.fixed    = 1'b1;
		ctl_c.check_tz = 1'b0;
		ctl_c.indet    = 1'b0;
		ctl_c.diff     = '0;
		if (identical) begin
			ctl_c.diff = '0;
		end else if (!compat) begin
			case (req_type_s1)
				pdtc_pkg::MODE_NORMAL: begin
					ctl_c.diff = $signed(pdtc_pkg::DIFF_W'(lhs_kind_s1))
					           - $signed(pdtc_pkg::DIFF_W'(rhs_kind_s1));
				end
				pdtc_pkg::MODE_STRICT: begin
					ctl_c.indet = 1'b1;
				end
				pdtc_pkg::MODE_STRICT_EQ: begin
					ctl_c.diff = -pdtc_pkg::DIFF_W'(1);
				end
				pdtc_pkg::MODE_ALT: begin
					ctl_c.diff = (lhs_kind_s1 != pdtc_pkg::SUB_TIME)
					           ? pdtc_pkg::DIFF_W'(1) : -pdtc_pkg::DIFF_W'(1);
				end
				default: begin
					ctl_c.diff = '0;
				end
			endcase
		end else if (lhs_low_precision_s1 || rhs_low_precision_s1) begin
			ctl_c.diff = ysat;
		end else begin
			ctl_c.fixed    = 1'b0;
			ctl_c.check_tz = ((req_type_s1 == pdtc_pkg::MODE_STRICT)
			               || (req_type_s1 == pdtc_pkg::MODE_STRICT_EQ))
			              && (lhs_bits_s1[pdtc_pkg::HAS_TZ_BIT]
			               != rhs_bits_s1[pdtc_pkg::HAS_TZ_BIT]);
		end
	end

	// Control travels alongside the timeline stages
	always_ff @(posedge clk) begin
		if (en.s2) ctl_s2 <= ctl_c;
		if (en.s3) ctl_s3 <= ctl_s2;
		if (en.s4) ctl_s4 <= ctl_s3;
	end

	pdtc_timeline u_lhs_tl (
		.clk      (clk),
		.en       (en),
		.subtype  (lhs_kind_s1),
		.negative (lhs_negative_s1),
		.bits     (lhs_bits_s1),
		.secs     (lhs_secs)
	);

	pdtc_timeline u_rhs_tl (
		.clk      (clk),
		.en       (en),
		.subtype  (rhs_kind_s1),
		.negative (rhs_negative_s1),
		.bits     (rhs_bits_s1),
		.secs     (rhs_secs)
	);

	// Timeline difference and the fourteen-hour window
	always_comb begin
		tdiff     = pdtc_pkg::DIFF_W'(lhs_secs) - pdtc_pkg::DIFF_W'(rhs_secs);
		in_window = (tdiff <= pdtc_pkg::TZ_WINDOW) && (tdiff >= -pdtc_pkg::TZ_WINDOW);
	end

	// Result register
	always_ff @(posedge clk) begin
		if (rdy5) begin
			difference_q    <= ctl_s4.fixed ? ctl_s4.diff : tdiff;
			indeterminate_q <= ctl_s4.fixed ? ctl_s4.indet : (ctl_s4.check_tz && in_window);
		end
	end

	assign res_valid     = res_valid_q;
	assign difference    = difference_q;
	assign indeterminate = indeterminate_q;

endmodule

// File: src/pdtc_checker.sv
// ---------------------------------------------------------------------------
// Packed date/time comparator checker
// Port-level assertions on result hold, latency and the indeterminate flag.
// ---------------------------------------------------------------------------
`include "packed_datetime_comparator_macros.svh"

module pdtc_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                req_valid,
	input logic                                req_ready,
	input logic                                res_valid,
	input logic                                res_ready,
	input logic signed [pdtc_pkg::DIFF_W-1:0]  difference,
	input logic                                indeterminate
);

	// A stalled result transaction keeps its payload
	`PDTC_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(difference) && $stable(indeterminate), "result changed while stalled")

	// With the receiver ready throughout, an accepted request comes out as a valid result
	`PDTC_ASSERT_NEXT(a_latency, (req_valid && req_ready) ##1 res_ready ##1 res_ready ##1 res_ready ##1 res_ready, res_valid, "result missing after pipeline latency")

	// An undecided order only ever comes with a gap inside fourteen hours
	`PDTC_ASSERT_SAME(a_indet_window, res_valid && indeterminate, (difference <= pdtc_pkg::TZ_WINDOW) && (difference >= -pdtc_pkg::TZ_WINDOW), "indeterminate outside the timezone window")

endmodule

bind packed_datetime_comparator pdtc_checker u_pdtc_checker (.*);
